// ----- src/lvtr_pkg.sv -----
package lvtr_pkg;

	localparam int unsigned STEP_BITS  = 16;
	localparam int unsigned DELAY_BITS = 11;
	localparam int unsigned KIND_BITS  = 2;

	localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd256;

	localparam logic [KIND_BITS-1:0] KIND_SET  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_GET  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_TICK = 2'd2;

	localparam logic RES_STATUS = 1'b0;
	localparam logic RES_UPDATE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GOAL,
		ST_DIV_GAP,
		ST_WAIT_GAP,
		ST_DIV_PER,
		ST_WAIT_PER,
		ST_COMMIT,
		ST_TICK,
		ST_FIRE,
		ST_EMIT_STAT,
		ST_EMIT_UPD,
		ST_DROP
	} lvtr_state_t;

	typedef struct packed {
		logic cap;
		logic set_goal;
		logic div_go_gap;
		logic div_go_per;
		logic latch_steps;
		logic commit_set;
		logic tick_dec;
		logic tick_expire;
		logic fire;
		logic emit_load;
		logic emit_upd;
	} lvtr_cmd_t;

	typedef struct packed {
		logic armed;
		logic cnt_gt1;
		logic steps_zero;
		logic div_done;
		logic want;
		logic out_free;
	} lvtr_stat_t;

endpackage

// ----- src/lightness_transition_ramp.sv -----
// Channel   Handshake             Beat payload
// in        in_valid / in_stall   kind, level, transition_ms, delay_ms, want_status
// out       out_valid / out_stall result_kind, current_level, target_level,
//                                 remaining_ms, done_res
// cfg       cfg_we                cfg_wdata (step_size)
//
// One input beat is taken at a time; in_stall is high from the cycle after acceptance
// until the item is finished. A get emits a status, a reserved beat is dropped, a tick
// counts down or, on expiry, steps the level and emits an update; a set runs the serial
// divider for the step count and, if a step is needed, the step period, then commits
// and emits a status if asked. A result waits in the output register; a stalled output holds
// the block in its emit state. Reset clears the ramp state and loads a step size of 256.
module lightness_transition_ramp #(
	parameter int unsigned LEVEL_BITS = 16,
	parameter int unsigned TIME_BITS  = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lvtr_pkg::STEP_BITS-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lvtr_pkg::KIND_BITS-1:0]    kind,
	input  logic [LEVEL_BITS-1:0]             level,
	input  logic [TIME_BITS-1:0]              transition_ms,
	input  logic [lvtr_pkg::DELAY_BITS-1:0]   delay_ms,
	input  logic                              want_status,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              result_kind,
	output logic [LEVEL_BITS-1:0]             current_level,
	output logic [LEVEL_BITS-1:0]             target_level,
	output logic [TIME_BITS-1:0]              remaining_ms,
	output logic                              done_res
);

	import lvtr_pkg::*;

	lvtr_cmd_t  cmd;
	lvtr_stat_t stat;

	lvtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lvtr_dp #(
		.LEVEL_BITS (LEVEL_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.level         (level),
		.transition_ms (transition_ms),
		.delay_ms      (delay_ms),
		.want_status   (want_status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.current_level (current_level),
		.target_level  (target_level),
		.remaining_ms  (remaining_ms),
		.done_res      (done_res)
	);

endmodule

// ----- src/lvtr_div.sv -----
module lvtr_div #(
	parameter int unsigned DVD_BITS = 26,
	parameter int unsigned DVS_BITS = 16,
	parameter int unsigned CNT_BITS = $clog2(DVD_BITS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CNT_BITS-1:0] cnt_init,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DVS_BITS-1:0] divisor,
	output logic [DVD_BITS-1:0] quo,
	output logic                done
);

	logic [DVD_BITS-1:0] quo_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [DVS_BITS-1:0] divs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [DVS_BITS:0]   partial;
	logic [DVS_BITS:0]   diff;
	logic                ge;

	always_comb begin
		partial = {rem_q, quo_q[DVD_BITS-1]};
		ge      = partial >= {1'b0, divs_q};
		diff    = partial - {1'b0, divs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= cnt_init;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_BITS'(1);
			done_q <= cnt_q == CNT_BITS'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			divs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_BITS-2:0], ge};
			rem_q <= ge ? diff[DVS_BITS-1:0] : partial[DVS_BITS-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ----- src/lvtr_dp.sv -----
module lvtr_dp #(
	parameter int unsigned LEVEL_BITS = 16,
	parameter int unsigned TIME_BITS  = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lvtr_pkg::lvtr_cmd_t               cmd,
	output lvtr_pkg::lvtr_stat_t              stat,
	input  logic                              cfg_we,
	input  logic [lvtr_pkg::STEP_BITS-1:0]    cfg_wdata,
	input  logic [LEVEL_BITS-1:0]             level,
	input  logic [TIME_BITS-1:0]              transition_ms,
	input  logic [lvtr_pkg::DELAY_BITS-1:0]   delay_ms,
	input  logic                              want_status,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              result_kind,
	output logic [LEVEL_BITS-1:0]             current_level,
	output logic [LEVEL_BITS-1:0]             target_level,
	output logic [TIME_BITS-1:0]              remaining_ms,
	output logic                              done_res
);

	import lvtr_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(TIME_BITS + 1);

	logic [STEP_BITS-1:0]  step_size_q;
	logic [LEVEL_BITS-1:0] level_in_q;
	logic [TIME_BITS-1:0]  ttime_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic                  want_q;

	logic [LEVEL_BITS-1:0] level_now_q;
	logic [LEVEL_BITS-1:0] level_goal_q;
	logic [TIME_BITS-1:0]  time_left_q;
	logic [TIME_BITS-1:0]  step_period_q;
	logic [TIME_BITS-1:0]  countdown_q;
	logic                  armed_q;
	logic [LEVEL_BITS-1:0] steps_q;
	logic                  fire_done_q;

	logic                  out_valid_q;
	logic                  result_kind_q;
	logic [LEVEL_BITS-1:0] current_level_q;
	logic [LEVEL_BITS-1:0] target_level_q;
	logic [TIME_BITS-1:0]  remaining_ms_q;
	logic                  done_res_q;

	logic [STEP_BITS-1:0]  eff_step;
	logic [LEVEL_BITS-1:0] gap;
	logic                  finish;
	logic [STEP_BITS:0]    lvl_up;
	logic [STEP_BITS:0]    lvl_dn;
	logic [TIME_BITS-1:0]  rem;
	logic                  out_free;

	logic                  div_start;
	logic [CNT_BITS-1:0]   div_cnt;
	logic [TIME_BITS-1:0]  div_dvd;
	logic [STEP_BITS-1:0]  div_dvs;
	logic [TIME_BITS-1:0]  div_quo;
	logic                  div_done;

	always_comb begin
		eff_step = (step_size_q == '0) ? STEP_BITS'(1) : step_size_q;
		gap      = (level_goal_q > level_now_q) ? level_goal_q - level_now_q
		                                        : level_now_q - level_goal_q;
		finish   = (time_left_q <= step_period_q) || (STEP_BITS'(gap) <= eff_step);
		lvl_up   = (STEP_BITS+1)'(level_now_q) + (STEP_BITS+1)'(eff_step);
		lvl_dn   = (STEP_BITS+1)'(level_now_q) - (STEP_BITS+1)'(eff_step);
		rem      = (time_left_q != '0) ? time_left_q : (armed_q ? countdown_q : '0);
		out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		div_start = cmd.div_go_gap || cmd.div_go_per;
		if (cmd.div_go_gap) begin
			div_cnt = CNT_BITS'(LEVEL_BITS);
			div_dvd = TIME_BITS'(gap) << (TIME_BITS - LEVEL_BITS);
			div_dvs = eff_step;
		end else begin
			div_cnt = CNT_BITS'(TIME_BITS);
			div_dvd = ttime_q;
			div_dvs = STEP_BITS'(steps_q);
		end
	end

	lvtr_div #(
		.DVD_BITS (TIME_BITS),
		.DVS_BITS (STEP_BITS),
		.CNT_BITS (CNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.cnt_init (div_cnt),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quo      (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q <= 1'b0;
		end else if (cmd.cap) begin
			want_q <= want_status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			level_in_q <= level;
			ttime_q    <= transition_ms;
			delay_q    <= delay_ms;
		end
		if (cmd.latch_steps) begin
			steps_q <= div_quo[LEVEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_now_q   <= '0;
			level_goal_q  <= '0;
			time_left_q   <= '0;
			step_period_q <= '0;
			countdown_q   <= '0;
			armed_q       <= 1'b0;
			fire_done_q   <= 1'b0;
		end else begin
			if (cmd.set_goal) begin
				level_goal_q <= level_in_q;
			end
			if (cmd.commit_set) begin
				step_period_q <= (steps_q == '0) ? '0 : div_quo;
				time_left_q   <= ttime_q;
				countdown_q   <= TIME_BITS'(delay_q);
				armed_q       <= 1'b1;
			end
			if (cmd.tick_dec) begin
				countdown_q <= countdown_q - TIME_BITS'(1);
			end
			if (cmd.tick_expire) begin
				countdown_q <= '0;
				time_left_q <= (time_left_q > step_period_q) ? time_left_q - step_period_q
				                                             : '0;
			end
			if (cmd.fire) begin
				fire_done_q <= finish;
				if (finish) begin
					level_now_q <= level_goal_q;
					time_left_q <= '0;
					armed_q     <= 1'b0;
					countdown_q <= '0;
				end else begin
					level_now_q <= (level_goal_q > level_now_q) ? lvl_up[LEVEL_BITS-1:0]
					                                            : lvl_dn[LEVEL_BITS-1:0];
					countdown_q <= step_period_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			result_kind_q   <= cmd.emit_upd ? RES_UPDATE : RES_STATUS;
			current_level_q <= level_now_q;
			target_level_q  <= level_goal_q;
			remaining_ms_q  <= rem;
			done_res_q      <= cmd.emit_upd && fire_done_q;
		end
	end

	always_comb begin
		stat.armed      = armed_q;
		stat.cnt_gt1    = countdown_q > TIME_BITS'(1);
		stat.steps_zero = steps_q == '0;
		stat.div_done   = div_done;
		stat.want       = want_q;
		stat.out_free   = out_free;
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = result_kind_q;
	assign current_level = current_level_q;
	assign target_level  = target_level_q;
	assign remaining_ms  = remaining_ms_q;
	assign done_res      = done_res_q;

endmodule

// ----- src/lvtr_ctrl.sv -----
module lvtr_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [lvtr_pkg::KIND_BITS-1:0]   kind,
	output logic                             in_stall,
	input  lvtr_pkg::lvtr_stat_t             stat,
	output lvtr_pkg::lvtr_cmd_t              cmd
);

	import lvtr_pkg::*;

	lvtr_state_t state_q;
	lvtr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					case (kind)
						KIND_SET:  state_d = ST_GOAL;
						KIND_GET:  state_d = ST_EMIT_STAT;
						KIND_TICK: state_d = ST_TICK;
						default:   state_d = ST_DROP;
					endcase
				end
			end
			ST_GOAL: begin
				cmd.set_goal = 1'b1;
				state_d      = ST_DIV_GAP;
			end
			ST_DIV_GAP: begin
				cmd.div_go_gap = 1'b1;
				state_d        = ST_WAIT_GAP;
			end
			ST_WAIT_GAP: begin
				if (stat.div_done) begin
					cmd.latch_steps = 1'b1;
					state_d         = ST_DIV_PER;
				end
			end
			ST_DIV_PER: begin
				if (stat.steps_zero) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.div_go_per = 1'b1;
					state_d        = ST_WAIT_PER;
				end
			end
			ST_WAIT_PER: begin
				if (stat.div_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit_set = 1'b1;
				state_d        = stat.want ? ST_EMIT_STAT : ST_IDLE;
			end
			ST_TICK: begin
				if (!stat.armed) begin
					state_d = ST_IDLE;
				end else if (stat.cnt_gt1) begin
					cmd.tick_dec = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.tick_expire = 1'b1;
					state_d         = ST_FIRE;
				end
			end
			ST_FIRE: begin
				cmd.fire = 1'b1;
				state_d  = ST_EMIT_UPD;
			end
			ST_EMIT_STAT: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EMIT_UPD: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					cmd.emit_upd  = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_DROP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/lvtr_chk.sv -----
module lvtr_chk #(
	parameter int unsigned LEVEL_BITS = 16,
	parameter int unsigned TIME_BITS  = 26
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [lvtr_pkg::KIND_BITS-1:0]    kind,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              result_kind,
	input logic [LEVEL_BITS-1:0]             current_level,
	input logic [LEVEL_BITS-1:0]             target_level,
	input logic [TIME_BITS-1:0]              remaining_ms,
	input logic                              done_res
);

	import lvtr_pkg::*;

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(current_level)
			&& $stable(target_level) && $stable(remaining_ms) && $stable(done_res)
			&& $stable(result_kind))
		else $error("stalled result beat changed");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while an item is in progress");

	a_status_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_STATUS |-> !done_res)
		else $error("status beat flagged done");

	a_done_lands: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_UPDATE && done_res
			|-> current_level == target_level && remaining_ms == '0)
		else $error("final update not at target");

	a_get_reply: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_GET && !out_valid |-> ##2 out_valid)
		else $error("get beat produced no status in time");

endmodule

bind lightness_transition_ramp lvtr_chk #(
	.LEVEL_BITS (LEVEL_BITS),
	.TIME_BITS  (TIME_BITS)
) u_lvtr_chk (.*);
